// ===== hdl/z80cb_pkg.sv =====
// Shared types and constants for the CB-group rotate / bit unit.
`timescale 1ns / 1ps
package z80cb_pkg;

    // Flag bit positions in F: S Z Y H X PV N C
    localparam int F_C_BIT  = 0;
    localparam int F_N_BIT  = 1;
    localparam int F_PV_BIT = 2;
    localparam int F_X_BIT  = 3;
    localparam int F_H_BIT  = 4;
    localparam int F_Y_BIT  = 5;
    localparam int F_Z_BIT  = 6;
    localparam int F_S_BIT  = 7;

    // Opcode x field
    typedef enum logic [1:0] {
        X_ROT = 2'd0,
        X_BIT = 2'd1,
        X_RES = 2'd2,
        X_SET = 2'd3
    } t_op_group;

    // Rotate / shift kind in y field
    typedef enum logic [2:0] {
        SH_RLC = 3'd0,
        SH_RRC = 3'd1,
        SH_RL  = 3'd2,
        SH_RR  = 3'd3,
        SH_SLA = 3'd4,
        SH_SRA = 3'd5,
        SH_SLL = 3'd6,
        SH_SRL = 3'd7
    } t_shift_kind;

    localparam logic [2:0] Z_MEM     = 3'd6;
    localparam logic [2:0] Y_SIGN    = 3'd7;

    localparam logic [4:0] T_REG     = 5'd8;
    localparam logic [4:0] T_BIT_HL  = 5'd12;
    localparam logic [4:0] T_RMW_HL  = 5'd15;
    localparam logic [4:0] T_BIT_IDX = 5'd20;
    localparam logic [4:0] T_RMW_IDX = 5'd23;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  opcode;
        logic [7:0]  operand_value;
        logic [7:0]  flags_in;
        logic [15:0] base_address;
        logic [7:0]  displacement;
        logic [7:0]  memptr_high;
    } t_item;

    typedef struct packed {
        logic [7:0]  result_value;
        logic [7:0]  flags_out;
        logic        write_register;
        logic [2:0]  register_index;
        logic        write_memory;
        logic [15:0] memory_address;
        logic        memptr_write;
        logic [15:0] memptr_value;
        logic [4:0]  t_states;
    } t_result;

endpackage

// ===== hdl/z80cb_exec.sv =====
// Decode and execute logic for one CB-group opcode.
`timescale 1ns / 1ps
module z80cb_exec
    import z80cb_pkg::*;
(
    input  t_item   i_item,
    output t_result o_result
);

    t_op_group   grp;
    t_shift_kind kind;
    logic [2:0]  y;
    logic [2:0]  z;
    logic [7:0]  val;
    logic [7:0]  fin;
    logic [7:0]  mask;
    logic [15:0] idx_addr;
    logic [7:0]  xysrc;
    logic [7:0]  sh_r;
    logic        sh_c;
    logic        cin;
    logic        bit_set;
    logic        is_mem;

    assign grp      = t_op_group'(i_item.opcode[7:6]);
    assign kind     = t_shift_kind'(i_item.opcode[5:3]);
    assign y        = i_item.opcode[5:3];
    assign z        = i_item.opcode[2:0];
    assign val      = i_item.operand_value;
    assign fin      = i_item.flags_in;
    assign cin      = fin[F_C_BIT];
    assign mask     = 8'd1 << y;
    assign is_mem   = (z == Z_MEM);
    assign idx_addr = i_item.base_address
                    + {{8{i_item.displacement[7]}}, i_item.displacement};
    assign bit_set  = |(val & mask);

    always_comb begin
        if (i_item.req_type) begin
            xysrc = idx_addr[15:8];
        end else if (is_mem) begin
            xysrc = i_item.memptr_high;
        end else begin
            xysrc = val;
        end
    end

    always_comb begin
        unique case (kind)
            SH_RLC: begin sh_c = val[7]; sh_r = {val[6:0], val[7]}; end
            SH_RRC: begin sh_c = val[0]; sh_r = {val[0], val[7:1]}; end
            SH_RL:  begin sh_c = val[7]; sh_r = {val[6:0], cin};    end
            SH_RR:  begin sh_c = val[0]; sh_r = {cin, val[7:1]};    end
            SH_SLA: begin sh_c = val[7]; sh_r = {val[6:0], 1'b0};   end
            SH_SRA: begin sh_c = val[0]; sh_r = {val[7], val[7:1]}; end
            SH_SLL: begin sh_c = val[7]; sh_r = {val[6:0], 1'b1};   end
            SH_SRL: begin sh_c = val[0]; sh_r = {1'b0, val[7:1]};   end
            default: begin sh_c = 1'b0; sh_r = 8'd0; end
        endcase
    end

    always_comb begin
        o_result                = '0;
        o_result.result_value   = val;
        o_result.flags_out      = fin;
        o_result.t_states       = T_REG;
        if (i_item.req_type) begin
            o_result.memory_address = idx_addr;
            o_result.memptr_write   = 1'b1;
            o_result.memptr_value   = idx_addr;
        end else if (is_mem) begin
            o_result.memory_address = i_item.base_address;
        end

        unique case (grp) inside
            X_BIT: begin
                o_result.flags_out           = '0;
                o_result.flags_out[F_C_BIT]  = cin;
                o_result.flags_out[F_H_BIT]  = 1'b1;
                o_result.flags_out[F_X_BIT]  = xysrc[F_X_BIT];
                o_result.flags_out[F_Y_BIT]  = xysrc[F_Y_BIT];
                o_result.flags_out[F_Z_BIT]  = ~bit_set;
                o_result.flags_out[F_PV_BIT] = ~bit_set;
                o_result.flags_out[F_S_BIT]  = (y == Y_SIGN) && bit_set;
                if (i_item.req_type) begin
                    o_result.t_states = T_BIT_IDX;
                end else if (is_mem) begin
                    o_result.t_states = T_BIT_HL;
                end
            end
            X_ROT, X_RES, X_SET: begin
                if (grp == X_ROT) begin
                    o_result.result_value        = sh_r;
                    o_result.flags_out           = '0;
                    o_result.flags_out[F_C_BIT]  = sh_c;
                    o_result.flags_out[F_S_BIT]  = sh_r[7];
                    o_result.flags_out[F_X_BIT]  = sh_r[F_X_BIT];
                    o_result.flags_out[F_Y_BIT]  = sh_r[F_Y_BIT];
                    o_result.flags_out[F_Z_BIT]  = (sh_r == 8'd0);
                    o_result.flags_out[F_PV_BIT] = ~^sh_r;
                end else if (grp == X_RES) begin
                    o_result.result_value = val & ~mask;
                end else begin
                    o_result.result_value = val | mask;
                end
                if (i_item.req_type) begin
                    o_result.write_memory = 1'b1;
                    o_result.t_states     = T_RMW_IDX;
                    if (!is_mem) begin
                        o_result.write_register = 1'b1;
                        o_result.register_index = z;
                    end
                end else if (is_mem) begin
                    o_result.write_memory = 1'b1;
                    o_result.t_states     = T_RMW_HL;
                end else begin
                    o_result.write_register = 1'b1;
                    o_result.register_index = z;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/z80_cb_bit_rotate_unit.sv =====
// A transfer is captured in the input register; its result appears with o_valid from the result register.
// Throughput: one item per cycle; busy is never asserted, input and result registers pipeline.
// The work is one registered pass: input register, decode/shift/flag logic, result register.
// Reset (synchronous, active low) clears the valid pipeline; payload registers are not reset.
// The receiver cannot stall: each result strobes for exactly one cycle.
`timescale 1ns / 1ps
module z80_cb_bit_rotate_unit
    import z80cb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic [7:0]         i_opcode,
    input  logic [7:0]         i_operand_value,
    input  logic [7:0]         i_flags_in,
    input  logic [15:0]        i_base_address,
    input  logic signed [7:0]  i_displacement,
    input  logic [7:0]         i_memptr_high,
    output logic               o_valid,
    output logic [7:0]         o_result_value,
    output logic [7:0]         o_flags_out,
    output logic               o_write_register,
    output logic [2:0]         o_register_index,
    output logic               o_write_memory,
    output logic [15:0]        o_memory_address,
    output logic               o_memptr_write,
    output logic [15:0]        o_memptr_value,
    output logic [4:0]         o_t_states
);

    logic    accept;
    logic    r_in_vld;
    t_item   r_item;
    t_item   n_item;
    t_result exec_res;
    t_result r_res;
    logic    r_out_vld;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        n_item.req_type      = i_req_type;
        n_item.opcode        = i_opcode;
        n_item.operand_value = i_operand_value;
        n_item.flags_in      = i_flags_in;
        n_item.base_address  = i_base_address;
        n_item.displacement  = i_displacement;
        n_item.memptr_high   = i_memptr_high;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= accept;
            r_out_vld <= r_in_vld;
        end
    end

    // hold payload unless a transfer lands
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
        if (r_in_vld) begin
            r_res <= exec_res;
        end
    end

    z80cb_exec u_exec (
        .i_item   (r_item),
        .o_result (exec_res)
    );

    assign o_valid          = r_out_vld;
    assign o_result_value   = r_res.result_value;
    assign o_flags_out      = r_res.flags_out;
    assign o_write_register = r_res.write_register;
    assign o_register_index = r_res.register_index;
    assign o_write_memory   = r_res.write_memory;
    assign o_memory_address = r_res.memory_address;
    assign o_memptr_write   = r_res.memptr_write;
    assign o_memptr_value   = r_res.memptr_value;
    assign o_t_states       = r_res.t_states;

`ifndef ASSERT_OFF
    a_valid_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_in_vld) |-> o_valid)
        else $error("result strobe lost after execute stage");

    a_memptr_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_memptr_write |-> o_memptr_value == o_memory_address)
        else $error("MEMPTR update differs from indexed address");

    a_no_reg_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_register |-> o_register_index == 3'd0)
        else $error("register index set without register write");

    a_mem_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_write_memory |-> o_t_states == T_RMW_HL || o_t_states == T_RMW_IDX)
        else $error("memory write with wrong T-state count");

    a_reg_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_write_register && !o_memptr_write |-> !o_write_memory)
        else $error("plain register op also writes memory");
`endif

endmodule

// ===== tb/tb_z80_cb_bit_rotate_unit.sv =====
// Self-checking testbench for the CB-group rotate / bit unit: directed and random opcodes.
`timescale 1ns / 1ps
module tb_z80_cb_bit_rotate_unit
    import z80cb_pkg::*;
();

    localparam int  CYCLE_LIMIT  = 100000;
    localparam int  RANDOM_ITEMS = 750;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  REPORT_LIMIT = 10;

    localparam logic REQ_PLAIN   = 1'b0;
    localparam logic REQ_INDEXED = 1'b1;

    localparam logic [2:0] REG_B = 3'd0;
    localparam logic [2:0] REG_C = 3'd1;
    localparam logic [2:0] REG_D = 3'd2;
    localparam logic [2:0] REG_E = 3'd3;
    localparam logic [2:0] REG_H = 3'd4;
    localparam logic [2:0] REG_L = 3'd5;
    localparam logic [2:0] REG_A = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_req_type = 1'b0;
    logic [7:0]  i_opcode = 8'h00;
    logic [7:0]  i_operand_value = 8'h00;
    logic [7:0]  i_flags_in = 8'h00;
    logic [15:0] i_base_address = 16'h0000;
    logic signed [7:0] i_displacement = 8'sh00;
    logic [7:0]  i_memptr_high = 8'h00;
    logic        o_valid;
    logic [7:0]  o_result_value;
    logic [7:0]  o_flags_out;
    logic        o_write_register;
    logic [2:0]  o_register_index;
    logic        o_write_memory;
    logic [15:0] o_memory_address;
    logic        o_memptr_write;
    logic [15:0] o_memptr_value;
    logic [4:0]  o_t_states;

    z80_cb_bit_rotate_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_opcode         (i_opcode),
        .i_operand_value  (i_operand_value),
        .i_flags_in       (i_flags_in),
        .i_base_address   (i_base_address),
        .i_displacement   (i_displacement),
        .i_memptr_high    (i_memptr_high),
        .o_valid          (o_valid),
        .o_result_value   (o_result_value),
        .o_flags_out      (o_flags_out),
        .o_write_register (o_write_register),
        .o_register_index (o_register_index),
        .o_write_memory   (o_write_memory),
        .o_memory_address (o_memory_address),
        .o_memptr_write   (o_memptr_write),
        .o_memptr_value   (o_memptr_value),
        .o_t_states       (o_t_states)
    );

    t_item   opcodes_pending[$];
    t_result cb_results_due[$];
    t_item   opcode_on_bus;
    t_result seen_result;
    t_result due_result;
    int      opcodes_total = 0;
    int      opcodes_sent = 0;
    int      idle_left = 0;
    bit      no_idle_burst = 0;
    bit      field_wrong;
    int      fail_count = 0;
    int      cycle_count = 0;

    function automatic logic [7:0] cb_opcode(t_op_group grp, logic [2:0] y, logic [2:0] z);
        return {grp, y, z};
    endfunction

    function automatic t_item cb_item(logic req, logic [7:0] op, logic [7:0] val,
                                      logic [7:0] fin, logic [15:0] base,
                                      logic [7:0] disp, logic [7:0] mhi);
        t_item it;
        it.req_type      = req;
        it.opcode        = op;
        it.operand_value = val;
        it.flags_in      = fin;
        it.base_address  = base;
        it.displacement  = disp;
        it.memptr_high   = mhi;
        return it;
    endfunction

    // Work out the write-back, flags and timing of one CB-group opcode.
    function automatic t_result cb_execute(t_item it);
        t_result     r;
        t_op_group   grp;
        logic [2:0]  y;
        logic [2:0]  z;
        logic [7:0]  val;
        logic [7:0]  fin;
        logic [7:0]  xy_src;
        logic [7:0]  shifted;
        logic        carry;
        logic        bit_set;
        grp = t_op_group'(it.opcode[7:6]);
        y   = it.opcode[5:3];
        z   = it.opcode[2:0];
        val = it.operand_value;
        fin = it.flags_in;
        r   = '0;
        r.result_value = val;
        r.flags_out    = fin;

        if (it.req_type == REQ_INDEXED) begin
            r.memory_address = it.base_address + {{8{it.displacement[7]}}, it.displacement};
            r.memptr_write   = 1'b1;
            r.memptr_value   = r.memory_address;
            xy_src           = r.memory_address[15:8];
        end else begin
            if (z == Z_MEM) r.memory_address = it.base_address;
            xy_src = (z == Z_MEM) ? it.memptr_high : val;
        end

        if (grp == X_BIT) begin
            bit_set = val[y];
            r.flags_out = '0;
            r.flags_out[F_C_BIT] = fin[F_C_BIT];
            r.flags_out[F_H_BIT] = 1'b1;
            r.flags_out[F_X_BIT] = xy_src[F_X_BIT];
            r.flags_out[F_Y_BIT] = xy_src[F_Y_BIT];
            if (!bit_set) begin
                r.flags_out[F_Z_BIT]  = 1'b1;
                r.flags_out[F_PV_BIT] = 1'b1;
            end
            if (y == Y_SIGN && bit_set) r.flags_out[F_S_BIT] = 1'b1;
            if (it.req_type == REQ_INDEXED) r.t_states = T_BIT_IDX;
            else r.t_states = (z == Z_MEM) ? T_BIT_HL : T_REG;
        end else begin
            if (grp == X_ROT) begin
                case (t_shift_kind'(y))
                    SH_RLC: begin carry = val[7]; shifted = {val[6:0], val[7]}; end
                    SH_RRC: begin carry = val[0]; shifted = {val[0], val[7:1]}; end
                    SH_RL:  begin carry = val[7]; shifted = {val[6:0], fin[F_C_BIT]}; end
                    SH_RR:  begin carry = val[0]; shifted = {fin[F_C_BIT], val[7:1]}; end
                    SH_SLA: begin carry = val[7]; shifted = {val[6:0], 1'b0}; end
                    SH_SRA: begin carry = val[0]; shifted = {val[7], val[7:1]}; end
                    SH_SLL: begin carry = val[7]; shifted = {val[6:0], 1'b1}; end
                    default: begin carry = val[0]; shifted = {1'b0, val[7:1]}; end
                endcase
                r.result_value = shifted;
                r.flags_out = '0;
                r.flags_out[F_S_BIT]  = shifted[7];
                r.flags_out[F_Z_BIT]  = (shifted == 8'h00);
                r.flags_out[F_Y_BIT]  = shifted[5];
                r.flags_out[F_X_BIT]  = shifted[3];
                r.flags_out[F_PV_BIT] = ~^shifted;
                r.flags_out[F_C_BIT]  = carry;
            end else if (grp == X_RES) begin
                r.result_value = val & ~(8'h01 << y);
            end else begin
                r.result_value = val | (8'h01 << y);
            end

            if (it.req_type == REQ_INDEXED) begin
                r.write_memory = 1'b1;
                if (z != Z_MEM) begin
                    r.write_register = 1'b1;
                    r.register_index = z;
                end
                r.t_states = T_RMW_IDX;
            end else if (z == Z_MEM) begin
                r.write_memory = 1'b1;
                r.t_states     = T_RMW_HL;
            end else begin
                r.write_register = 1'b1;
                r.register_index = z;
                r.t_states       = T_REG;
            end
        end
        return r;
    endfunction

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("z80_cb_bit_rotate_unit: mismatch");
            $finish;
        end
    end

    // Driver: hold an item until it transfers, then idle a random number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left = 0;
        end else begin
            if (start && !busy) begin
                cb_results_due.push_back(cb_execute(opcode_on_bus));
                opcodes_sent = opcodes_sent + 1;
                if ($urandom_range(0, 63) == 0) no_idle_burst = !no_idle_burst;
                idle_left = no_idle_burst ? 0 : $urandom_range(0, 5);
            end
            if (start && busy) begin
                // hold the current item on the bus
            end else if (idle_left > 0) begin
                idle_left = idle_left - 1;
                start <= 1'b0;
            end else if (opcodes_pending.size() > 0) begin
                opcode_on_bus = opcodes_pending.pop_front();
                i_req_type      <= opcode_on_bus.req_type;
                i_opcode        <= opcode_on_bus.opcode;
                i_operand_value <= opcode_on_bus.operand_value;
                i_flags_in      <= opcode_on_bus.flags_in;
                i_base_address  <= opcode_on_bus.base_address;
                i_displacement  <= opcode_on_bus.displacement;
                i_memptr_high   <= opcode_on_bus.memptr_high;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check each strobed result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seen_result.result_value   = o_result_value;
            seen_result.flags_out      = o_flags_out;
            seen_result.write_register = o_write_register;
            seen_result.register_index = o_register_index;
            seen_result.write_memory   = o_write_memory;
            seen_result.memory_address = o_memory_address;
            seen_result.memptr_write   = o_memptr_write;
            seen_result.memptr_value   = o_memptr_value;
            seen_result.t_states       = o_t_states;
            if (cb_results_due.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result at %0t: %h", $realtime, seen_result);
            end else begin
                due_result = cb_results_due.pop_front();
                field_wrong = 1'b0;
                if (seen_result.result_value   !== due_result.result_value)   field_wrong = 1'b1;
                if (seen_result.flags_out      !== due_result.flags_out)      field_wrong = 1'b1;
                if (seen_result.write_register !== due_result.write_register) field_wrong = 1'b1;
                if (seen_result.register_index !== due_result.register_index) field_wrong = 1'b1;
                if (seen_result.write_memory   !== due_result.write_memory)   field_wrong = 1'b1;
                if (seen_result.memory_address !== due_result.memory_address) field_wrong = 1'b1;
                if (seen_result.memptr_write   !== due_result.memptr_write)   field_wrong = 1'b1;
                if (seen_result.memptr_value   !== due_result.memptr_value)   field_wrong = 1'b1;
                if (seen_result.t_states       !== due_result.t_states)       field_wrong = 1'b1;
                if (field_wrong) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("result error at %0t", $realtime);
                        $display("  exp res=%h f=%h wr=%b ri=%0d wm=%b a=%h mw=%b mv=%h t=%0d",
                                 due_result.result_value, due_result.flags_out,
                                 due_result.write_register, due_result.register_index,
                                 due_result.write_memory, due_result.memory_address,
                                 due_result.memptr_write, due_result.memptr_value,
                                 due_result.t_states);
                        $display("  got res=%h f=%h wr=%b ri=%0d wm=%b a=%h mw=%b mv=%h t=%0d",
                                 seen_result.result_value, seen_result.flags_out,
                                 seen_result.write_register, seen_result.register_index,
                                 seen_result.write_memory, seen_result.memory_address,
                                 seen_result.memptr_write, seen_result.memptr_value,
                                 seen_result.t_states);
                    end
                end
            end
        end
    end

    initial begin
        logic [7:0]  val;
        logic [15:0] base;
        // Directed: every shift kind, carry in and out, zero and parity cases.
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_ROT, SH_RLC, REG_B),
                                          8'h80, 8'h00, 16'h1234, 8'h00, 8'h00));
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_ROT, SH_RRC, REG_C),
                                          8'h01, 8'hFF, 16'h1234, 8'h00, 8'h00));
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_ROT, SH_RL, REG_D),
                                          8'h80, 8'h01, 16'h0000, 8'h00, 8'h00));
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_ROT, SH_RR, REG_E),
                                          8'h01, 8'h00, 16'h0000, 8'h00, 8'h00));
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_ROT, SH_SLA, REG_H),
                                          8'hFF, 8'h00, 16'hFFFF, 8'hFF, 8'hFF));
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_ROT, SH_SRA, REG_L),
                                          8'h80, 8'h01, 16'h0000, 8'h00, 8'h00));
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_ROT, SH_SLL, REG_A),
                                          8'h00, 8'hFF, 16'h0000, 8'h00, 8'h00));
        // plain (HL): displacement must be ignored
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_ROT, SH_SRL, Z_MEM),
                                          8'hFF, 8'h00, 16'hFFFF, 8'h80, 8'h00));
        // BIT: sign from bit 7, zero on clear bit, X/Y from operand, MEMPTR or address
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_BIT, Y_SIGN, REG_A),
                                          8'h80, 8'h00, 16'h0000, 8'h00, 8'h00));
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_BIT, Y_SIGN, REG_B),
                                          8'h7F, 8'hFF, 16'h0000, 8'h00, 8'h00));
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_BIT, 3'd0, Z_MEM),
                                          8'h00, 8'h01, 16'hABCD, 8'h00, 8'h28));
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_BIT, 3'd3, REG_C),
                                          8'h28, 8'h00, 16'h0000, 8'h00, 8'hD7));
        opcodes_pending.push_back(cb_item(REQ_INDEXED, cb_opcode(X_BIT, 3'd5, Z_MEM),
                                          8'h20, 8'h00, 16'h2800, 8'h00, 8'h00));
        // indexed BIT with a register z: z is ignored, address wraps below zero
        opcodes_pending.push_back(cb_item(REQ_INDEXED, cb_opcode(X_BIT, 3'd1, REG_D),
                                          8'h00, 8'h00, 16'h0000, 8'hFF, 8'hFF));
        // RES / SET on registers and (HL)
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_RES, 3'd0, REG_B),
                                          8'hFF, 8'h5A, 16'h0000, 8'h00, 8'h00));
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_RES, Y_SIGN, Z_MEM),
                                          8'hFF, 8'hA5, 16'h0000, 8'h7F, 8'h00));
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_SET, Y_SIGN, REG_A),
                                          8'h00, 8'h00, 16'h0000, 8'h00, 8'h00));
        opcodes_pending.push_back(cb_item(REQ_PLAIN, cb_opcode(X_SET, 3'd0, Z_MEM),
                                          8'h00, 8'hFF, 16'hFFFF, 8'h00, 8'h00));
        // indexed: address wrap above 0xFFFF, register copy, negative displacement
        opcodes_pending.push_back(cb_item(REQ_INDEXED, cb_opcode(X_ROT, SH_RLC, Z_MEM),
                                          8'h00, 8'h00, 16'hFFFF, 8'h01, 8'h00));
        opcodes_pending.push_back(cb_item(REQ_INDEXED, cb_opcode(X_ROT, SH_RR, REG_A),
                                          8'h01, 8'h01, 16'h1234, 8'h7F, 8'h00));
        opcodes_pending.push_back(cb_item(REQ_INDEXED, cb_opcode(X_RES, 3'd3, REG_B),
                                          8'hFF, 8'h00, 16'h8000, 8'h80, 8'h00));
        opcodes_pending.push_back(cb_item(REQ_INDEXED, cb_opcode(X_SET, 3'd6, REG_L),
                                          8'h00, 8'hC3, 16'h00FF, 8'h01, 8'h00));
        opcodes_pending.push_back(cb_item(REQ_INDEXED, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
                                          8'hFF, 8'hFF));
        opcodes_pending.push_back(cb_item(REQ_PLAIN, 8'h00, 8'h00, 8'h00, 16'h0000,
                                          8'h00, 8'h00));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(0, 7))
                0: val = 8'h00;
                1: val = 8'hFF;
                2: val = ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h01;
                default: val = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 9))
                0: base = 16'h0000;
                1: base = 16'hFFFF;
                default: base = 16'($urandom_range(0, 65535));
            endcase
            opcodes_pending.push_back(cb_item(1'($urandom_range(0, 1)),
                                              8'($urandom_range(0, 255)), val,
                                              8'($urandom_range(0, 255)), base,
                                              8'($urandom_range(0, 255)),
                                              8'($urandom_range(0, 255))));
        end
        opcodes_total = opcodes_pending.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (opcodes_sent < opcodes_total) @(posedge i_clk);
        while (cb_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        fail_count = fail_count + cb_results_due.size();

        if (fail_count == 0) begin
            $display("z80_cb_bit_rotate_unit: match");
        end else begin
            $display("z80_cb_bit_rotate_unit: mismatch");
        end
        $finish;
    end

endmodule
